>>> hdl/i2r_pkg.sv
`default_nettype none

package i2r_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned CharW  = 7;
  localparam int unsigned DigW   = 4;
  localparam int unsigned NumDig = 4;
  localparam int unsigned BcdW   = DigW * NumDig;

  localparam logic [ValueW-1:0] MaxValue = ValueW'(3999);

  // ascii letters
  localparam logic [CharW-1:0] ChNul = 7'h00;
  localparam logic [CharW-1:0] ChI   = 7'h49;
  localparam logic [CharW-1:0] ChV   = 7'h56;
  localparam logic [CharW-1:0] ChX   = 7'h58;
  localparam logic [CharW-1:0] ChL   = 7'h4C;
  localparam logic [CharW-1:0] ChC   = 7'h43;
  localparam logic [CharW-1:0] ChD   = 7'h44;
  localparam logic [CharW-1:0] ChM   = 7'h4D;

  // decimal positions, most significant first
  localparam logic [1:0] DigThou = 2'd3;
  localparam logic [1:0] DigHund = 2'd2;
  localparam logic [1:0] DigTens = 2'd1;
  localparam logic [1:0] DigUnit = 2'd0;

  typedef enum logic [1:0] {
    SYM_ONE  = 2'd0,
    SYM_FIVE = 2'd1,
    SYM_TEN  = 2'd2
  } sym_e;

  typedef struct packed {
    logic            done;
    logic [BcdW-1:0] digits;
  } bcd_res_t;

  // number of letters a decimal digit turns into
  function automatic logic [2:0] digit_len(input logic [DigW-1:0] d);
    logic [2:0] len;
    case (d)
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // which letter of the digit's group stands at position pos
  function automatic sym_e digit_sym(input logic [DigW-1:0] d, input logic [1:0] pos);
    sym_e s;
    s = SYM_ONE;
    if (d == 4'd9) begin
      s = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
    end else if (d >= 4'd5) begin
      s = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
    end else if (d == 4'd4) begin
      s = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
    end
    return s;
  endfunction

  function automatic logic [CharW-1:0] letter(input logic [1:0] pos10, input sym_e s);
    logic [CharW-1:0] c;
    c = ChM;
    case (pos10)
      DigUnit: begin
        case (s)
          SYM_FIVE: c = ChV;
          SYM_TEN:  c = ChX;
          default:  c = ChI;
        endcase
      end
      DigTens: begin
        case (s)
          SYM_FIVE: c = ChL;
          SYM_TEN:  c = ChC;
          default:  c = ChX;
        endcase
      end
      DigHund: begin
        case (s)
          SYM_FIVE: c = ChD;
          SYM_TEN:  c = ChM;
          default:  c = ChC;
        endcase
      end
      default: c = ChM;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/i2r_in_if.sv
`default_nettype none

interface i2r_in_if;
  logic                       valid;
  logic                       ready;
  logic [i2r_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> hdl/i2r_out_if.sv
`default_nettype none

interface i2r_out_if;
  logic                      valid;
  logic                      ready;
  logic [i2r_pkg::CharW-1:0] char_code;
  logic                      last;
  logic                      range_error;

  modport source (output valid, output char_code, output last, output range_error,
                  input ready);
  modport sink   (input valid, input char_code, input last, input range_error,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/i2r_bcd.sv
`default_nettype none

// bit-serial binary to bcd conversion (shift and add three), one bit per cycle
module i2r_bcd (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [i2r_pkg::ValueW-1:0] value_i,
  output      i2r_pkg::bcd_res_t          res_o
);
  import i2r_pkg::*;

  localparam int unsigned CntW = $clog2(ValueW + 1);

  logic [ValueW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d, bcd_adj;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      if (bcd_q[i*DigW +: DigW] >= DigW'(5)) begin
        bcd_adj[i*DigW +: DigW] = bcd_q[i*DigW +: DigW] + DigW'(3);
      end else begin
        bcd_adj[i*DigW +: DigW] = bcd_q[i*DigW +: DigW];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = CntW'(ValueW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign res_o.done   = done_q;
  assign res_o.digits = bcd_q;

endmodule

`default_nettype wire

>>> hdl/integer_to_roman_numeral.sv
// a value is taken in idle, shifted through the bcd converter and loaded into the digit
// register; zero digits are skipped and each letter goes into the output register
// a new value is taken only once the last letter of the previous one is in the output
// register, after the 12-step bcd shift and one letter per cycle unless the output stalls
// out of range values give one error result through the error state, then back to idle
// reset: rst_ni asynchronous active low, clears the sequencer and output valid
`default_nettype none

module integer_to_roman_numeral (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  i2r_in_if.sink    req_i,
  i2r_out_if.source res_o
);
  import i2r_pkg::*;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_EMIT = 4'b0100,
    S_ERR  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // digit shift register: current digit always in the top nibble
  logic [BcdW-1:0] digits_q, digits_d;
  logic [1:0]      dig_idx_q, dig_idx_d;   // decimal position of top nibble
  logic [1:0]      pos_q, pos_d;           // letter position inside the digit

  // output register
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             err_q, err_d;

  logic       req_fire;
  logic       slot_free;
  logic       bad_value;
  logic [DigW-1:0] cur_dig;
  logic [2:0] cur_len;
  logic       pos_end;
  logic       run_end;
  bcd_res_t   bcd_res;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  // value of zero or above 3999 has no numeral
  assign bad_value   = (req_i.value == '0) || (req_i.value > MaxValue);

  // output register can take a new letter this cycle
  assign slot_free = !out_valid_q || res_o.ready;

  i2r_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (req_fire && !bad_value),
    .value_i (req_i.value),
    .res_o   (bcd_res)
  );

  assign cur_dig = digits_q[BcdW-1 -: DigW];
  assign cur_len = digit_len(cur_dig);
  assign pos_end = ({1'b0, pos_q} + 3'd1) == cur_len;
  // last letter of the run once every lower digit is zero
  assign run_end = pos_end && (digits_q[BcdW-DigW-1:0] == '0);

  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    dig_idx_d   = dig_idx_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !res_o.ready;
    char_d      = char_q;
    last_d      = last_q;
    err_d       = err_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = bad_value ? S_ERR : S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_res.done) begin
          digits_d  = bcd_res.digits;
          dig_idx_d = DigThou;
          pos_d     = 2'd0;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cur_len == 3'd0) begin
          // zero digit gives no letters, move on
          digits_d  = {digits_q[BcdW-DigW-1:0], {DigW{1'b0}}};
          dig_idx_d = dig_idx_q - 2'd1;
          pos_d     = 2'd0;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = letter(dig_idx_q, digit_sym(cur_dig, pos_q));
          last_d      = run_end;
          err_d       = 1'b0;
          if (pos_end) begin
            digits_d  = {digits_q[BcdW-DigW-1:0], {DigW{1'b0}}};
            dig_idx_d = dig_idx_q - 2'd1;
            pos_d     = 2'd0;
          end else begin
            pos_d = pos_q + 2'd1;
          end
          if (run_end) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = ChNul;
          last_d      = 1'b1;
          err_d       = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dig_idx_q   <= '0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dig_idx_q   <= dig_idx_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    char_q   <= char_d;
    last_q   <= last_d;
    err_q    <= err_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.char_code   = char_q;
  assign res_o.last        = last_q;
  assign res_o.range_error = err_q;

endmodule

`default_nettype wire
